/* src/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, register indexes and constants for pressure compensation.
// ----------------------------------------------------------------------------
package bpc_pkg;

   localparam int unsigned DivSteps = 32;

   typedef enum logic [2:0] {
      REG_AC1  = 3'd0,
      REG_AC2  = 3'd1,
      REG_AC3  = 3'd2,
      REG_AC4  = 3'd3,
      REG_B1   = 3'd4,
      REG_B2   = 3'd5,
      REG_OSS  = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [15:0] ac1;
      logic [15:0] ac2;
      logic [15:0] ac3;
      logic [15:0] ac4;
      logic [15:0] b1;
      logic [15:0] b2;
      logic [1:0]  oss;
   } cal_type;

   // operands handed from the front end to the divider
   typedef struct packed {
      logic [31:0] num;
      logic [31:0] den;
      logic        post_shift;
      logic        fault;
   } div_req_type;

   localparam logic [31:0] B6Offset   = 32'd4000;
   localparam logic [31:0] B4Offset   = 32'd32768;
   localparam logic [31:0] B7Scale    = 32'd50000;
   localparam logic [31:0] SignBit    = 32'h8000_0000;
   localparam logic [31:0] CoefX1     = 32'd3038;
   localparam logic [31:0] CoefX2     = 32'd7357;
   localparam logic [31:0] CoefOffset = 32'd3791;

endpackage

/* src/bpc_front.sv */
// ----------------------------------------------------------------------------
// bpc_front
// Pipelined B3/B4/B7 computation, at most one multiplier level per stage.
// ----------------------------------------------------------------------------
module bpc_front
   import bpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cal_type     cal,
   input  logic        in_valid,
   input  logic [18:0] in_up,
   input  logic [23:0] in_b5,
   output logic        out_valid,
   output div_req_type out_req
);

   logic [31:0] ac1, ac2, ac3, ac4, b1, b2;
   assign ac1 = {{16{cal.ac1[15]}}, cal.ac1};
   assign ac2 = {{16{cal.ac2[15]}}, cal.ac2};
   assign ac3 = {{16{cal.ac3[15]}}, cal.ac3};
   assign ac4 = {16'd0, cal.ac4};
   assign b1  = {{16{cal.b1[15]}}, cal.b1};
   assign b2  = {{16{cal.b2[15]}}, cal.b2};

   // stage 1: b6
   logic [4:0] v_ff, v_in;
   logic [31:0] s1_b6_ff, s1_b6_in;
   logic [18:0] s1_up_ff, s2_up_ff, s3_up_ff;
   assign s1_b6_in = {{8{in_b5[23]}}, in_b5} - B6Offset;

   // stage 2: b6*b6, ac2*b6, ac3*b6
   logic [31:0] s2_sq_ff, s2_sq_in, s2_a2_ff, s2_a3_ff;
   assign s2_sq_in = s1_b6_ff * s1_b6_ff;

   // stage 3: b2*sq, b1*sq
   logic [31:0] sq, s3_b2_ff, s3_b1_ff, s3_a2_ff, s3_a3_ff;
   assign sq = 32'($signed(s2_sq_ff) >>> 12);

   // stage 4: b3, x3 for b4
   logic [31:0] x3a, b3_t, b3_in, x1b, x2b, x3b_in;
   logic [31:0] s4_b3_ff, s4_x3_ff;
   logic [18:0] s4_up_ff;
   assign x3a   = 32'($signed(s3_b2_ff) >>> 11) + 32'($signed(s3_a2_ff) >>> 11);
   assign b3_t  = ((ac1 << 2) + x3a) << cal.oss;
   assign b3_in = 32'($signed(b3_t + 32'd2) >>> 2);
   assign x1b   = 32'($signed(s3_a3_ff) >>> 13);
   assign x2b   = 32'($signed(s3_b1_ff) >>> 16);
   assign x3b_in = 32'($signed(x1b + x2b + 32'd2) >>> 2);

   // stage 5: b4 and b7 products
   logic [31:0] b4_p, b7_p, b4;
   logic [31:0] s5_b4p_ff, s5_b7_ff;
   assign b4_p = ac4 * (s4_x3_ff + B4Offset);
   assign b7_p = ({13'd0, s4_up_ff} - s4_b3_ff) * (B7Scale >> cal.oss);

   assign b4 = s5_b4p_ff >> 15;
   always_comb begin
      v_in = {v_ff[3:0], in_valid};
      out_valid = v_ff[4];
      out_req.den = b4;
      out_req.fault = (b4 == 32'd0);
      out_req.post_shift = (s5_b7_ff >= SignBit);
      out_req.num = out_req.post_shift ? s5_b7_ff : (s5_b7_ff << 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
      s1_b6_ff <= s1_b6_in;
      s1_up_ff <= in_up;
      s2_sq_ff <= s2_sq_in;
      s2_a2_ff <= ac2 * s1_b6_ff;
      s2_a3_ff <= ac3 * s1_b6_ff;
      s2_up_ff <= s1_up_ff;
      s3_b2_ff <= b2 * sq;
      s3_b1_ff <= b1 * sq;
      s3_a2_ff <= s2_a2_ff;
      s3_a3_ff <= s2_a3_ff;
      s3_up_ff <= s2_up_ff;
      s4_b3_ff <= b3_in;
      s4_x3_ff <= x3b_in;
      s4_up_ff <= s3_up_ff;
      s5_b4p_ff <= b4_p;
      s5_b7_ff <= b7_p;
   end

endmodule

/* src/bpc_divider.sv */
// ----------------------------------------------------------------------------
// bpc_divider
// Unsigned 32/32 restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module bpc_divider
   import bpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  div_req_type in_req,
   output logic        out_valid,
   output logic [31:0] out_p,
   output logic        out_fault
);

   logic [DivSteps-1:0] v_ff;
   logic [31:0]         rem_ff [DivSteps];
   logic [31:0]         quo_ff [DivSteps];
   logic [31:0]         den_ff [DivSteps];
   logic [DivSteps-1:0] sh_ff;
   logic [DivSteps-1:0] flt_ff;

   for (genvar i = 0; i < DivSteps; i++) begin : g_step
      logic        v_src, sh_src, flt_src;
      logic [31:0] rem_src, quo_src, den_src;
      logic [32:0] trial;
      logic [32:0] shifted;
      if (i == 0) begin : g_src
         assign v_src   = in_valid;
         assign rem_src = '0;
         assign quo_src = in_req.num;
         assign den_src = in_req.den;
         assign sh_src  = in_req.post_shift;
         assign flt_src = in_req.fault;
      end else begin : g_src
         assign v_src   = v_ff[i-1];
         assign rem_src = rem_ff[i-1];
         assign quo_src = quo_ff[i-1];
         assign den_src = den_ff[i-1];
         assign sh_src  = sh_ff[i-1];
         assign flt_src = flt_ff[i-1];
      end
      assign shifted = {rem_src, quo_src[31]};
      assign trial = shifted - {1'b0, den_src};
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else begin
            v_ff[i] <= v_src;
         end
         if (!trial[32]) begin
            rem_ff[i] <= trial[31:0];
         end else begin
            rem_ff[i] <= shifted[31:0];
         end
         quo_ff[i] <= {quo_src[30:0], ~trial[32]};
         den_ff[i] <= den_src;
         sh_ff[i]  <= sh_src;
         flt_ff[i] <= flt_src;
      end
   end

   assign out_valid = v_ff[DivSteps-1];
   assign out_fault = flt_ff[DivSteps-1];
   assign out_p = flt_ff[DivSteps-1] ? 32'd0 :
                  (sh_ff[DivSteps-1] ? (quo_ff[DivSteps-1] << 1) : quo_ff[DivSteps-1]);

endmodule

/* src/bpc_back.sv */
// ----------------------------------------------------------------------------
// bpc_back
// Final pascal correction: p + ((x1 + x2 + 3791) >> 4), pipelined; zero on a divide fault.
// ----------------------------------------------------------------------------
module bpc_back
   import bpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_p,
   input  logic        in_fault,
   output logic        out_valid,
   output logic [31:0] out_p,
   output logic        out_fault
);

   logic [2:0]  v_ff, v_in;
   logic [31:0] p1_ff, p2_ff, p3_ff, sq_ff, x2m_ff, x1m_ff, x2_ff, p8;
   logic [2:0]  f_ff;
   logic [31:0] sum;

   assign p8 = 32'($signed(in_p) >>> 8);
   assign v_in = {v_ff[1:0], in_valid};
   assign sum = 32'($signed(x1m_ff) >>> 16) + x2_ff + CoefOffset;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
      p1_ff  <= in_p;
      sq_ff  <= p8 * p8;
      x2m_ff <= 32'd0 - CoefX2 * in_p;
      p2_ff  <= p1_ff;
      x1m_ff <= sq_ff * CoefX1;
      x2_ff  <= 32'($signed(x2m_ff) >>> 16);
      p3_ff  <= f_ff[1] ? 32'd0 : p2_ff + 32'($signed(sum) >>> 4);
      f_ff   <= {f_ff[1:0], in_fault};
   end

   assign out_valid = v_ff[2];
   assign out_p = p3_ff;
   assign out_fault = f_ff[2];

endmodule

/* src/barometric_pressure_compensation.sv */
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Raw pressure plus temperature term in, compensated pascals out.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with req_raw_pressure and req_temp_term; busy is always low,
//   so a request is taken in every cycle, back to back.
//   Each request gives one result; rsp_valid is high for one
//   cycle with rsp_pressure_pa and rsp_divide_fault.
//   Pipeline: 5 front stages, 32 divider stages (one quotient bit each) and
//   3 correction stages. Throughput: one request per cycle.
//   Calibration must be written through csr_we/csr_index/csr_wdata while idle
//   (the block itself does not enforce this); indexes beyond the list are ignored.
//   Synchronous reset clears all valid bits and the calibration registers.
//   The receiver cannot stall; results are not held.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation
   import bpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [18:0] req_raw_pressure,
   input  logic signed [23:0] req_temp_term,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_pressure_pa,
   output logic        rsp_divide_fault,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cal_type     cal_ff;
   logic        fv, dv;
   div_req_type dreq;
   logic [31:0] dp, bp;
   logic        dflt;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_AC1: cal_ff.ac1 <= csr_wdata;
            REG_AC2: cal_ff.ac2 <= csr_wdata;
            REG_AC3: cal_ff.ac3 <= csr_wdata;
            REG_AC4: cal_ff.ac4 <= csr_wdata;
            REG_B1:  cal_ff.b1  <= csr_wdata;
            REG_B2:  cal_ff.b2  <= csr_wdata;
            REG_OSS: cal_ff.oss <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   bpc_front u_front (
      .clock, .reset, .cal(cal_ff), .in_valid(start && !busy),
      .in_up(req_raw_pressure), .in_b5(req_temp_term),
      .out_valid(fv), .out_req(dreq)
   );

   bpc_divider u_div (
      .clock, .reset, .in_valid(fv), .in_req(dreq),
      .out_valid(dv), .out_p(dp), .out_fault(dflt)
   );

   bpc_back u_back (
      .clock, .reset, .in_valid(dv), .in_p(dp), .in_fault(dflt),
      .out_valid(rsp_valid), .out_p(bp), .out_fault(rsp_divide_fault)
   );

   assign rsp_pressure_pa = bp;

endmodule

/* src/bpc_checker.sv */
// ----------------------------------------------------------------------------
// bpc_port_checks
// Port-level checks on the compensation block.
// ----------------------------------------------------------------------------
module bpc_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_pressure_pa,
   input logic        rsp_divide_fault
);

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_fault |-> rsp_pressure_pa == 32'd0)
      else $error("fault result not zero");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##40 rsp_valid)
      else $error("result missing after request");

   a_no_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result right after reset");

endmodule

bind barometric_pressure_compensation bpc_port_checks u_bpc_port_checks (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_pressure_pa, .rsp_divide_fault
);
